// ----- rtl/transparent_pixel_color_bleed_assert.svh -----
// Assertion macros for the alpha bleed block.
`ifndef TRANSPARENT_PIXEL_COLOR_BLEED_ASSERT_SVH
`define TRANSPARENT_PIXEL_COLOR_BLEED_ASSERT_SVH
`ifndef SYNTH
`define TPCB_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TPCB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPCB_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define TPCB_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- rtl/tpcb_pkg.sv -----
`timescale 1ns / 1ps
package tpcb_pkg;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;
    localparam int CW = 9;
    localparam int QDEPTH = 2;

    localparam logic [1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_REGION_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_REGION_HEIGHT = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic          operation;
        logic [7:0]    x_pos;
        logic [7:0]    y_pos;
        logic [7:0]    in_red;
        logic [7:0]    in_green;
        logic [7:0]    in_blue;
        logic [7:0]    in_alpha;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } t_out_item;

    // classified command from front to back
    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_READ_ZERO,
        CMD_READ_RAW,
        CMD_READ_BLEED
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        logic [XW-1:0] left;
        logic [XW-1:0] right;
        logic [YW-1:0] top;
        logic [YW-1:0] bottom;
        logic [31:0] data;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTER,
        ST_SCAN,
        ST_DIV,
        ST_OUT
    } t_back_state;
endpackage

// ----- rtl/tpcb_if.sv -----
`timescale 1ns / 1ps
interface tpcb_in_if;
    import tpcb_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tpcb_out_if;
    import tpcb_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/tpcb_front.sv -----
`timescale 1ns / 1ps
module tpcb_front
    import tpcb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in_item   i_item,
    input  logic [8:0] i_fw,
    input  logic [8:0] i_fh,
    input  logic [8:0] i_rw,
    input  logic [8:0] i_rh,
    output logic       o_valid,
    input  logic       i_ready,
    output t_cmd       o_cmd
);
    t_cmd r_q [QDEPTH];
    logic [$clog2(QDEPTH)-1:0] r_wp, r_rp;
    logic [$clog2(QDEPTH):0] r_cnt;
    logic [8:0] fw, fh, rw, rh, x9, y9, sx, sy;
    logic in_frame, colx, rowy, push, pop;
    t_cmd cmd;

    always_comb begin
        fw = (i_fw > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : i_fw;
        fh = (i_fh > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : i_fh;
        rw = (i_rw > fw) ? fw : i_rw;
        if (rw == 9'd0) begin
            rw = 9'd1;
        end
        rh = (i_rh > fh) ? fh : i_rh;
        if (rh == 9'd0) begin
            rh = 9'd1;
        end
        x9 = {1'b0, i_item.x_pos};
        y9 = {1'b0, i_item.y_pos};
        in_frame = (x9 < fw) && (y9 < fh);
        colx = (rw < fw) && (x9 == rw);
        rowy = (rh < fh) && (y9 == rh);
        sx = x9;
        sy = y9;
        if (colx && y9 < rh) begin
            sx = rw - 9'd1;
        end else if (rowy && x9 < rw) begin
            sy = rh - 9'd1;
        end else if (colx && rowy) begin
            sx = rw - 9'd1;
            sy = rh - 9'd1;
        end
        cmd.x = XW'(sx);
        cmd.y = YW'(sy);
        cmd.left = (sx == 9'd0) ? '0 : XW'(sx - 9'd1);
        cmd.right = (sx + 9'd1 < fw) ? XW'(sx + 9'd1) : XW'(fw - 9'd1);
        cmd.top = (sy == 9'd0) ? '0 : YW'(sy - 9'd1);
        cmd.bottom = (sy + 9'd1 < fh) ? YW'(sy + 9'd1) : YW'(fh - 9'd1);
        cmd.data = {i_item.in_alpha, i_item.in_blue, i_item.in_green, i_item.in_red};
        if (i_item.operation == OP_WRITE) begin
            cmd.kind = CMD_WRITE;
            cmd.x = XW'(x9);
            cmd.y = YW'(y9);
        end else if (!in_frame) begin
            cmd.kind = CMD_READ_ZERO;
        end else if (fw < 9'd2 || fh < 9'd2) begin
            cmd.kind = CMD_READ_RAW;
            cmd.x = XW'(x9);
            cmd.y = YW'(y9);
        end else begin
            cmd.kind = CMD_READ_BLEED;
        end
    end

    // drop writes outside the frame
    assign o_ready = (r_cnt != QDEPTH[$clog2(QDEPTH):0]);
    assign push = i_valid && o_ready && !(i_item.operation == OP_WRITE && !in_frame);
    assign pop = o_valid && i_ready;
    assign o_valid = (r_cnt != '0);
    assign o_cmd = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end
endmodule

// ----- rtl/tpcb_back.sv -----
`timescale 1ns / 1ps
module tpcb_back
    import tpcb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_cmd      i_cmd,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);
    logic [31:0] r_mem [MAX_WIDTH*MAX_HEIGHT];
    logic [31:0] r_rd;
    t_back_state r_st, n_st;
    t_cmd r_cmd;
    logic [XW-1:0] r_cx, n_cx;
    logic [YW-1:0] r_cy, n_cy;
    logic r_pend, n_pend, r_last, n_last;
    logic [11:0] r_sr, r_sg, r_sb, n_sr, n_sg, n_sb;
    logic [3:0] r_n, n_n;
    logic [31:0] r_ctr, n_ctr;
    logic [7:0] r_qr, r_qg, r_qb, n_qr, n_qg, n_qb;
    logic [11:0] r_rr, r_rg, r_rb, n_rr, n_rg, n_rb;
    logic [3:0] r_it, n_it;
    logic [31:0] r_res, n_res;
    logic rd_en, wr_en;
    logic [AW-1:0] rd_addr;
    logic [12:0] tr, tg, tb;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[{i_cmd.y, i_cmd.x}] <= i_cmd.data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
        end else begin
            r_st <= n_st;
        end
        r_cx <= n_cx; r_cy <= n_cy; r_pend <= n_pend; r_last <= n_last;
        r_sr <= n_sr; r_sg <= n_sg; r_sb <= n_sb; r_n <= n_n; r_ctr <= n_ctr;
        r_qr <= n_qr; r_qg <= n_qg; r_qb <= n_qb;
        r_rr <= n_rr; r_rg <= n_rg; r_rb <= n_rb; r_it <= n_it; r_res <= n_res;
        if (i_valid && o_ready) begin
            r_cmd <= i_cmd;
        end
    end

    always_comb begin
        n_st = r_st;
        n_cx = r_cx; n_cy = r_cy; n_pend = r_pend; n_last = r_last;
        n_sr = r_sr; n_sg = r_sg; n_sb = r_sb; n_n = r_n; n_ctr = r_ctr;
        n_qr = r_qr; n_qg = r_qg; n_qb = r_qb;
        n_rr = r_rr; n_rg = r_rg; n_rb = r_rb; n_it = r_it; n_res = r_res;
        o_ready = 1'b0;
        wr_en = 1'b0;
        rd_en = 1'b0;
        rd_addr = {r_cmd.y, r_cmd.x};
        tr = '0; tg = '0; tb = '0;
        case (r_st)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    case (i_cmd.kind)
                        CMD_WRITE: wr_en = 1'b1;
                        CMD_READ_ZERO: begin
                            n_res = '0;
                            n_st = ST_OUT;
                        end
                        default: begin
                            rd_en = 1'b1;
                            rd_addr = {i_cmd.y, i_cmd.x};
                            n_st = ST_CENTER;
                        end
                    endcase
                end
            end
            ST_CENTER: begin
                n_ctr = r_rd;
                n_res = r_rd;
                n_sr = '0; n_sg = '0; n_sb = '0; n_n = '0;
                n_cx = r_cmd.left;
                n_cy = r_cmd.top;
                n_pend = 1'b0;
                n_last = 1'b0;
                if (r_cmd.kind == CMD_READ_RAW || r_rd[31:24] != 8'd0) begin
                    n_st = ST_OUT;
                end else begin
                    n_st = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // accumulate last fetched word, issue next fetch
                if (r_pend && r_rd[31:24] != 8'd0) begin
                    n_sr = r_sr + 12'(r_rd[7:0]);
                    n_sg = r_sg + 12'(r_rd[15:8]);
                    n_sb = r_sb + 12'(r_rd[23:16]);
                    n_n = r_n + 4'd1;
                end
                if (r_last) begin
                    n_pend = 1'b0;
                    if (r_pend) begin
                        n_st = ST_DIV;
                        n_it = '0;
                        n_qr = '0; n_qg = '0; n_qb = '0;
                        n_rr = '0; n_rg = '0; n_rb = '0;
                    end
                end else begin
                    rd_en = 1'b1;
                    rd_addr = {r_cy, r_cx};
                    n_pend = 1'b1;
                    if (r_cx == r_cmd.right) begin
                        n_cx = r_cmd.left;
                        n_cy = r_cy + 1'b1;
                        n_last = (r_cy == r_cmd.bottom);
                    end else begin
                        n_cx = r_cx + 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (r_n == 4'd0) begin
                    n_res = r_ctr;
                    n_st = ST_OUT;
                end else begin
                    // one restoring step per channel
                    tr = {r_rr, r_sr[11 - r_it]};
                    tg = {r_rg, r_sg[11 - r_it]};
                    tb = {r_rb, r_sb[11 - r_it]};
                    if (tr >= 13'(r_n)) begin
                        tr = tr - 13'(r_n);
                        n_qr = {r_qr[6:0], 1'b1};
                    end else begin
                        n_qr = {r_qr[6:0], 1'b0};
                    end
                    if (tg >= 13'(r_n)) begin
                        tg = tg - 13'(r_n);
                        n_qg = {r_qg[6:0], 1'b1};
                    end else begin
                        n_qg = {r_qg[6:0], 1'b0};
                    end
                    if (tb >= 13'(r_n)) begin
                        tb = tb - 13'(r_n);
                        n_qb = {r_qb[6:0], 1'b1};
                    end else begin
                        n_qb = {r_qb[6:0], 1'b0};
                    end
                    n_rr = tr[11:0]; n_rg = tg[11:0]; n_rb = tb[11:0];
                    n_it = r_it + 4'd1;
                    if (r_it == 4'd11) begin
                        n_res = {r_ctr[31:24], n_qb, n_qg, n_qr};
                        n_st = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (i_ready) begin
                    n_st = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    assign o_valid = (r_st == ST_OUT);
    assign o_item.out_red = r_res[7:0];
    assign o_item.out_green = r_res[15:8];
    assign o_item.out_blue = r_res[23:16];
    assign o_item.out_alpha = r_res[31:24];
endmodule

// ----- rtl/transparent_pixel_color_bleed.sv -----
`timescale 1ns / 1ps
// Alpha bleed over a stored RGBA frame.
// Input channel carries items: operation 0 writes a pixel, 1 reads a
// corrected pixel. Each read yields one result item on the output channel.
// Configuration: write i_cfg_we with i_cfg_index 0..3 (frame width, frame
// height, region width, region height) and i_cfg_data; only while idle.
// A front stage classifies each item and clamps the window; a two-entry
// queue feeds the back stage, which owns the single-port frame memory.
// Writes are done by the back stage while idle. A read of an opaque pixel
// goes from the memory read straight to the output; a transparent one
// fetches up to nine window words one per cycle from the memory port,
// then a 12-step bit-serial divider runs.
// Reset (synchronous, active low) empties the queue, idles the back stage
// and sets all dimensions to 256. The frame memory is not cleared.
// A stalled receiver holds the result; the queue then fills and the input
// channel deasserts ready.
module transparent_pixel_color_bleed
    import tpcb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    tpcb_in_if.sink    in_ch,
    tpcb_out_if.source out_ch,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data
);
`include "transparent_pixel_color_bleed_assert.svh"
    logic [8:0] r_fw, r_fh, r_rw, r_rh;
    logic q_valid, q_ready;
    t_cmd q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= 9'd256; r_fh <= 9'd256; r_rw <= 9'd256; r_rh <= 9'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH: r_fw <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_fh <= i_cfg_data;
                CFG_REGION_WIDTH: r_rw <= i_cfg_data;
                CFG_REGION_HEIGHT: r_rh <= i_cfg_data;
                default: r_rh <= r_rh;
            endcase
        end
    end

    tpcb_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_ch.valid), .o_ready(in_ch.ready), .i_item(in_ch.data),
        .i_fw(r_fw), .i_fh(r_fh), .i_rw(r_rw), .i_rh(r_rh),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );

    tpcb_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready), .o_item(out_ch.data)
    );

    `TPCB_ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data), "result dropped while stalled")
    `TPCB_ASSERT_IMPL(a_zero_out, i_clk, i_rst_n, q_valid && q_ready && q_cmd.kind == CMD_READ_ZERO |=> out_ch.valid && out_ch.data == '0, "outside read not zero")
    `TPCB_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !out_ch.valid, "result after reset")
endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import tpcb_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [8:0] i_cfg_data;

    tpcb_in_if  in_ch ();
    tpcb_out_if out_ch ();

    transparent_pixel_color_bleed u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch.sink),
        .out_ch      (out_ch.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    logic [31:0] pix_mem [0:MAX_HEIGHT-1][0:MAX_WIDTH-1];
    int unsigned fr_w, fr_h, rg_w, rg_h;

    t_in_item  pending_items[$];
    t_out_item expected_pixels[$];
    int        mismatches;
    int        reads_checked;
    int        items_sent;
    bit        calm;
    int        src_gap, snk_gap;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] bleed_pixel(int unsigned x, int unsigned y,
                                                int unsigned fw, int unsigned fh);
        logic [31:0] p;
        int unsigned l, r, t, b, sr, sg, sb, n;
        p = pix_mem[y][x];
        if (p[31:24] != 8'd0) return p;
        l = (x > 0) ? x - 1 : 0;
        r = (x + 1 < fw) ? x + 1 : fw - 1;
        t = (y > 0) ? y - 1 : 0;
        b = (y + 1 < fh) ? y + 1 : fh - 1;
        sr = 0; sg = 0; sb = 0; n = 0;
        for (int yy = t; yy <= b; yy++)
            for (int xx = l; xx <= r; xx++)
                if (pix_mem[yy][xx][31:24] != 8'd0) begin
                    sr += pix_mem[yy][xx][7:0];
                    sg += pix_mem[yy][xx][15:8];
                    sb += pix_mem[yy][xx][23:16];
                    n++;
                end
        if (n == 0) return p;
        return {p[31:24], 8'(sb / n), 8'(sg / n), 8'(sr / n)};
    endfunction

    function automatic t_out_item predict_read(int unsigned x, int unsigned y);
        logic [31:0] p;
        int unsigned fw, fh, rw, rh, sx, sy;
        bit colx, rowy;
        t_out_item o;
        fw = (fr_w > MAX_WIDTH) ? MAX_WIDTH : fr_w;
        fh = (fr_h > MAX_HEIGHT) ? MAX_HEIGHT : fr_h;
        p = 32'd0;
        if (x < fw && y < fh) begin
            if (fw < 2 || fh < 2) begin
                p = pix_mem[y][x];
            end else begin
                rw = (rg_w > fw) ? fw : ((rg_w < 1) ? 1 : rg_w);
                rh = (rg_h > fh) ? fh : ((rg_h < 1) ? 1 : rg_h);
                sx = x; sy = y;
                colx = (rw < fw) && (x == rw);
                rowy = (rh < fh) && (y == rh);
                if (colx && y < rh) begin
                    sx = rw - 1;
                end else if (rowy && x < rw) begin
                    sy = rh - 1;
                end else if (colx && rowy) begin
                    sx = rw - 1; sy = rh - 1;
                end
                p = bleed_pixel(sx, sy, fw, fh);
            end
        end
        o.out_red = p[7:0];
        o.out_green = p[15:8];
        o.out_blue = p[23:16];
        o.out_alpha = p[31:24];
        return o;
    endfunction

    // model the item at acceptance
    function automatic void apply_item(t_in_item it);
        int unsigned fw, fh;
        fw = (fr_w > MAX_WIDTH) ? MAX_WIDTH : fr_w;
        fh = (fr_h > MAX_HEIGHT) ? MAX_HEIGHT : fr_h;
        if (it.operation == OP_WRITE) begin
            if (it.x_pos < fw && it.y_pos < fh)
                pix_mem[it.y_pos][it.x_pos] =
                    {it.in_alpha, it.in_blue, it.in_green, it.in_red};
        end else begin
            expected_pixels.push_back(predict_read(it.x_pos, it.y_pos));
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
            src_gap <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                apply_item(in_ch.data);
                items_sent++;
            end
            if (in_ch.valid && !in_ch.ready) begin
            end else if (src_gap > 0) begin
                in_ch.valid <= 1'b0;
                src_gap <= src_gap - 1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                in_ch.valid <= 1'b0;
                src_gap <= $urandom_range(0, 7);
            end else if (pending_items.size() > 0) begin
                in_ch.valid <= 1'b1;
                in_ch.data <= pending_items.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            snk_gap <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", out_ch.data);
                end else begin
                    t_out_item e;
                    e = expected_pixels.pop_front();
                    reads_checked++;
                    if (e.out_red !== out_ch.data.out_red
                        || e.out_green !== out_ch.data.out_green
                        || e.out_blue !== out_ch.data.out_blue
                        || e.out_alpha !== out_ch.data.out_alpha) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("pixel mismatch: expected %h got %h", e, out_ch.data);
                    end
                end
            end
            if (snk_gap > 0) begin
                out_ch.ready <= 1'b0;
                snk_gap <= snk_gap - 1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                snk_gap <= $urandom_range(0, 7);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic set_reg(logic [1:0] idx, int unsigned v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 9'(v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FRAME_WIDTH:  fr_w = v;
            CFG_FRAME_HEIGHT: fr_h = v;
            CFG_REGION_WIDTH: rg_w = v;
            default:          rg_h = v;
        endcase
    endtask

    task automatic set_frame(int unsigned fw, int unsigned fh, int unsigned rw,
                             int unsigned rh);
        set_reg(CFG_FRAME_WIDTH, fw);
        set_reg(CFG_FRAME_HEIGHT, fh);
        set_reg(CFG_REGION_WIDTH, rw);
        set_reg(CFG_REGION_HEIGHT, rh);
    endtask

    task automatic queue_item(bit op, int unsigned x, int unsigned y, logic [31:0] px);
        t_in_item it;
        it.operation = op ? OP_READ : OP_WRITE;
        it.x_pos = 8'(x);
        it.y_pos = 8'(y);
        {it.in_alpha, it.in_blue, it.in_green, it.in_red} = px;
        pending_items.push_back(it);
    endtask

    function automatic logic [31:0] rand_pixel();
        logic [31:0] p;
        p = $urandom;
        case ($urandom_range(0, 3))
            0: p[31:24] = 8'd0;
            1: p[31:24] = 8'd0;
            2: p[31:24] = 8'hFF;
            default: ;
        endcase
        return p;
    endfunction

    task automatic drain();
        while (pending_items.size() > 0 || in_ch.valid || expected_pixels.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // fill the frame, then read only pixels whose windows are fully written
    task automatic run_phase(int unsigned fw, int unsigned fh, int unsigned rw,
                             int unsigned rh, int n_rand);
        set_frame(fw, fh, rw, rh);
        for (int yy = 0; yy < fh; yy++)
            for (int xx = 0; xx < fw; xx++)
                queue_item(1'b0, xx, yy, rand_pixel());
        for (int k = 0; k < n_rand; k++) begin
            case ($urandom_range(0, 9))
                0: queue_item(1'b0, $urandom_range(0, 255), $urandom_range(0, 255), $urandom);
                1: queue_item(1'b1, $urandom_range(fw, 255), $urandom_range(0, 255), $urandom);
                2, 3, 4: queue_item(1'b0, $urandom_range(0, fw - 1), $urandom_range(0, fh - 1),
                                    rand_pixel());
                default: queue_item(1'b1, $urandom_range(0, fw - 1),
                                    $urandom_range(0, fh - 1), $urandom);
            endcase
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_FRAME_WIDTH;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        mismatches = 0;
        reads_checked = 0;
        items_sent = 0;
        calm = 1'b0;
        fr_w = 256; fr_h = 256; rg_w = 256; rg_h = 256;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: corners of the full frame, extremes of channels
        queue_item(1'b0, 0, 0, 32'h00FFFFFF);
        queue_item(1'b0, 1, 0, 32'hFF000000);
        queue_item(1'b0, 0, 1, 32'h01FFFFFF);
        queue_item(1'b0, 1, 1, 32'h00000000);
        queue_item(1'b0, 2, 0, 32'h80102030);
        queue_item(1'b0, 2, 1, 32'h00FFFFFF);
        queue_item(1'b0, 0, 2, 32'hFFFFFFFF);
        queue_item(1'b0, 1, 2, 32'h00000000);
        queue_item(1'b0, 2, 2, 32'h01FF00FF);
        queue_item(1'b1, 0, 0, 32'h0);
        queue_item(1'b1, 1, 0, 32'h0);
        queue_item(1'b1, 1, 1, 32'h0);
        queue_item(1'b0, 255, 255, 32'hFFFFFFFF);
        queue_item(1'b1, 255, 255, 32'h0);
        drain();
        run_phase(1, 1, 1, 1, 8);
        run_phase(1, 6, 1, 3, 10);
        run_phase(5, 1, 2, 1, 10);
        run_phase(2, 2, 1, 1, 20);
        run_phase(8, 6, 5, 4, 60);
        run_phase(6, 8, 9, 0, 50);
        run_phase(10, 7, 10, 7, 50);
        run_phase(4, 4, 3, 3, 30);
        calm = 1'b1;
        run_phase(7, 5, 6, 4, 40);

        $display("ran %0d items, checked %0d reads over several frame and region sizes",
                 items_sent, reads_checked);
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/tpcb_pkg.sv
rtl/tpcb_if.sv
rtl/tpcb_front.sv
rtl/tpcb_back.sv
rtl/transparent_pixel_color_bleed.sv
tb/sv/tb_top.sv
